FILE: src/threshold_blob_centroid_assert.svh
// Assertion macros for the checker file of the blob centroid block.
`ifndef THRESHOLD_BLOB_CENTROID_ASSERT_SVH
`define THRESHOLD_BLOB_CENTROID_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define TBC_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("blob centroid check failed");

// The condition holds in the cycle after the trigger.
`define TBC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("blob centroid check failed");

`endif

FILE: src/tbc_pkg.sv
// Shared constants, types and register indexes of the blob centroid block.
package tbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 4;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 21;
  localparam int SUM_W   = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int CENT_W  = 14;
  localparam int CONF_W  = 9;
  localparam int CONF_SHIFT = 6;

  localparam int DIV_W     = SUM_W + FRAC_BITS;
  localparam int DIVISOR_W = CNT_W;
  localparam int STEP_W    = $clog2(DIV_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CONF_W-1:0] CONF_FULL = CONF_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = CFG_IDX_W'(3);

  typedef struct packed {
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] min_area;
  } frame_totals_t;

  typedef struct packed {
    logic          push;
    frame_totals_t totals;
  } queue_push_t;

  typedef struct packed {
    logic          valid;
    logic          full;
    frame_totals_t totals;
  } queue_head_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_DIV_COL,
    B_DIV_ROW,
    B_DIV_CONF,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_CONF
  } div_op_t;

endpackage

FILE: src/threshold_blob_centroid.sv
// Top level of the thresholded blob centroid block.
//
//   channel   direction  handshake                      payload
//   pixel     in         pixel_valid / pixel_ready      pixel
//   result    out        result_valid / result_ready    detected, centroid_col,
//                                                       centroid_row, area, confidence
//   config    in         cfg_wen (no wait)              cfg_index, cfg_data
//
// Pixels are taken at one per cycle; the front end stalls every pixel while
// two frame totals already wait in the queue.
// The back end runs k 34-step divisions on the shared divider for a frame,
// where k is 0 when nothing is detected, 2 for a zero minimum area and
// otherwise 3, and then waits for result_ready.
// Reset clears the position counters, sums, queue and back end, and loads the
// registers with their default values.
module threshold_blob_centroid
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  detected,
  output logic [CENT_W-1:0]     centroid_col,
  output logic [CENT_W-1:0]     centroid_row,
  output logic [CNT_W-1:0]      area,
  output logic [CONF_W-1:0]     confidence,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. The user must write them only while the block is idle;
  // both halves use them directly, and the block itself does not enforce this.
  logic [PIX_W-1:0]  bright_threshold;
  logic [CNT_W-1:0]  min_area;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  queue_push_t qpush;
  queue_head_t head;
  logic        pop;
  div_req_t    dreq;
  div_rsp_t    drsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_threshold <= PIX_W'(128);
      min_area         <= CNT_W'(4);
      frame_width      <= SIZE_W'(640);
      frame_height     <= SIZE_W'(480);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_BRIGHT_THRESHOLD: bright_threshold <= cfg_data[PIX_W-1:0];
        REG_MIN_AREA:         min_area         <= cfg_data[CNT_W-1:0];
        REG_FRAME_WIDTH:      frame_width      <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg_data[SIZE_W-1:0];
        default: begin
          bright_threshold <= bright_threshold;
        end
      endcase
    end
  end

  // The front end accumulates each frame and hands its totals over at the
  // last pixel.
  tbc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .pixel            (pixel),
    .bright_threshold (bright_threshold),
    .min_area         (min_area),
    .frame_width      (frame_width),
    .frame_height     (frame_height),
    .queue_full       (head.full),
    .qpush            (qpush)
  );

  // The queue lets the pixel stream run on while an earlier frame is divided.
  tbc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .head  (head)
  );

  // One divider serves the column, row and confidence quotients in turn.
  tbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // The back end holds each result in its output register until it is taken.
  tbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .dreq         (dreq),
    .drsp         (drsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .detected     (detected),
    .centroid_col (centroid_col),
    .centroid_row (centroid_row),
    .area         (area),
    .confidence   (confidence)
  );

endmodule

FILE: src/tbc_front.sv
// Front end: pixel position tracking, thresholding and per-frame accumulation.
module tbc_front
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [PIX_W-1:0]      pixel,
  input  logic [PIX_W-1:0]      bright_threshold,
  input  logic [CNT_W-1:0]      min_area,
  input  logic [SIZE_W-1:0]     frame_width,
  input  logic [SIZE_W-1:0]     frame_height,
  input  logic                  queue_full,
  output queue_push_t           qpush
);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SUM_W-1:0]  sum_col;
  logic [SUM_W-1:0]  sum_row;
  logic [CNT_W-1:0]  count;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              bright;
  logic              accept;
  logic              row_end;
  logic              frame_end;
  logic [SUM_W-1:0]  sum_col_next;
  logic [SUM_W-1:0]  sum_row_next;
  logic [CNT_W-1:0]  count_next;

  // Out-of-range sizes are clamped to the supported frame.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (frame_width > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (frame_height > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign pixel_ready = !queue_full;
  assign accept      = pixel_valid && pixel_ready;
  assign bright      = pixel >= bright_threshold;
  assign col_inc     = SIZE_W'(col) + SIZE_W'(1);
  assign row_inc     = SIZE_W'(row) + SIZE_W'(1);
  assign row_end     = col_inc >= w_eff;
  assign frame_end   = row_end && (row_inc >= h_eff);

  assign sum_col_next = bright ? sum_col + SUM_W'(col) : sum_col;
  assign sum_row_next = bright ? sum_row + SUM_W'(row) : sum_row;
  assign count_next   = bright ? count + CNT_W'(1) : count;

  assign qpush.push            = accept && frame_end;
  assign qpush.totals.sum_col  = sum_col_next;
  assign qpush.totals.sum_row  = sum_row_next;
  assign qpush.totals.count    = count_next;
  assign qpush.totals.min_area = min_area;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      sum_col <= '0;
      sum_row <= '0;
      count   <= '0;
    end else if (accept) begin
      if (!row_end) begin
        col <= col_inc[COL_W-1:0];
      end else begin
        col <= '0;
      end
      if (frame_end) begin
        row     <= '0;
        sum_col <= '0;
        sum_row <= '0;
        count   <= '0;
      end else begin
        if (row_end) begin
          row <= row_inc[ROW_W-1:0];
        end
        sum_col <= sum_col_next;
        sum_row <= sum_row_next;
        count   <= count_next;
      end
    end
  end

endmodule

FILE: src/tbc_queue.sv
// Short queue of frame totals between the front end and the back end.
module tbc_queue
  import tbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_push_t qpush,
  input  logic        pop,
  output queue_head_t head
);

  frame_totals_t     mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign head.valid  = fill != '0;
  assign head.full   = fill == QCNT_W'(QUEUE_DEPTH);
  assign head.totals = mem[rd_ptr];
  assign do_push     = qpush.push && !head.full;
  assign do_pop      = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= qpush.totals;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: src/tbc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tbc_div
  import tbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [STEP_W-1:0]    step;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   diff;

  // Shift the next dividend bit into the remainder and try a subtraction.
  assign rem_sh = {rem, quo[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/tbc_back.sv
// Back end: per-frame detection decision, centroid and confidence divisions.
module tbc_back
  import tbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  queue_head_t       head,
  output logic              pop,
  output div_req_t          dreq,
  input  div_rsp_t          drsp,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              detected,
  output logic [CENT_W-1:0] centroid_col,
  output logic [CENT_W-1:0] centroid_row,
  output logic [CNT_W-1:0]  area,
  output logic [CONF_W-1:0] confidence
);

  back_state_t       state;
  back_state_t       state_next;
  frame_totals_t     tot;
  logic [CENT_W-1:0] qcol;
  logic [CENT_W-1:0] qrow;

  logic              det;
  logic              min_zero;
  div_op_t           op;
  logic              load_col;
  logic              load_row;
  logic              out_load;
  logic              out_det;
  logic [CENT_W-1:0] out_row;
  logic [CONF_W-1:0] out_conf;
  logic [CONF_W-1:0] conf_clamped;

  assign det      = (tot.count != '0) && (tot.count >= tot.min_area);
  assign min_zero = tot.min_area == '0;
  assign conf_clamped = (drsp.quotient > DIV_W'(CONF_FULL)) ? CONF_FULL
                                                             : drsp.quotient[CONF_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          state_next = B_LOAD;
        end
      end
      B_LOAD: begin
        state_next = det ? B_DIV_COL : B_OUT;
      end
      B_DIV_COL: begin
        if (drsp.done) begin
          state_next = B_DIV_ROW;
        end
      end
      B_DIV_ROW: begin
        if (drsp.done) begin
          state_next = min_zero ? B_OUT : B_DIV_CONF;
        end
      end
      B_DIV_CONF: begin
        if (drsp.done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (result_ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    dreq.start = 1'b0;
    op         = DIV_COL;
    load_col   = 1'b0;
    load_row   = 1'b0;
    out_load   = 1'b0;
    out_det    = 1'b0;
    out_row    = qrow;
    out_conf   = '0;
    case (state)
      B_IDLE: begin
        pop = head.valid;
      end
      B_LOAD: begin
        if (det) begin
          dreq.start = 1'b1;
          op         = DIV_COL;
        end else begin
          out_load = 1'b1;
        end
      end
      B_DIV_COL: begin
        if (drsp.done) begin
          load_col   = 1'b1;
          dreq.start = 1'b1;
          op         = DIV_ROW;
        end
      end
      B_DIV_ROW: begin
        if (drsp.done) begin
          load_row = 1'b1;
          if (min_zero) begin
            out_load = 1'b1;
            out_det  = 1'b1;
            out_row  = drsp.quotient[CENT_W-1:0];
            out_conf = CONF_FULL;
          end else begin
            dreq.start = 1'b1;
            op         = DIV_CONF;
          end
        end
      end
      B_DIV_CONF: begin
        if (drsp.done) begin
          out_load = 1'b1;
          out_det  = 1'b1;
          out_conf = conf_clamped;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Operands of the shared divider.
  always_comb begin
    case (op)
      DIV_COL: begin
        dreq.dividend = {tot.sum_col, FRAC_BITS'(0)};
        dreq.divisor  = tot.count;
      end
      DIV_ROW: begin
        dreq.dividend = {tot.sum_row, FRAC_BITS'(0)};
        dreq.divisor  = tot.count;
      end
      DIV_CONF: begin
        dreq.dividend = DIV_W'({tot.count, CONF_SHIFT'(0)});
        dreq.divisor  = tot.min_area;
      end
      default: begin
        dreq.dividend = '0;
        dreq.divisor  = tot.count;
      end
    endcase
  end

  assign result_valid = state == B_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tot <= head.totals;
    end
    if (load_col) begin
      qcol <= drsp.quotient[CENT_W-1:0];
    end
    if (load_row) begin
      qrow <= drsp.quotient[CENT_W-1:0];
    end
    if (out_load) begin
      detected     <= out_det;
      centroid_col <= out_det ? qcol : '0;
      centroid_row <= out_det ? out_row : '0;
      area         <= out_det ? tot.count : '0;
      confidence   <= out_conf;
    end
  end

endmodule

FILE: src/tbc_checker.sv
// Port-level checks of the blob centroid block and their binding.
`include "threshold_blob_centroid_assert.svh"

module tbc_checker
  import tbc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic              detected,
  input logic [CENT_W-1:0] centroid_col,
  input logic [CENT_W-1:0] centroid_row,
  input logic [CNT_W-1:0]  area,
  input logic [CONF_W-1:0] confidence
);

  // A stalled result keeps its payload.
  `TBC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(detected) && $stable(area) && $stable(confidence) && $stable(centroid_col) && $stable(centroid_row))

  // A frame without a detection reports all other fields as zero.
  `TBC_ASSERT_SAME(a_no_detect_zero, clk, rst, result_valid && !detected, centroid_col == '0 && centroid_row == '0 && area == '0 && confidence == '0)

  // A detection has a nonzero area and a confidence of at least one quarter.
  `TBC_ASSERT_SAME(a_detect_conf, clk, rst, result_valid && detected, area != '0 && confidence >= CONF_W'(64) && confidence <= CONF_FULL)

  // A centroid never lies past the last column or row of the largest frame.
  `TBC_ASSERT_SAME(a_centroid_range, clk, rst, result_valid && detected, centroid_col <= CENT_W'((MAX_WIDTH - 1) * 16) && centroid_row <= CENT_W'((MAX_HEIGHT - 1) * 16))

endmodule

bind threshold_blob_centroid tbc_checker u_tbc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .detected     (detected),
  .centroid_col (centroid_col),
  .centroid_row (centroid_row),
  .area         (area),
  .confidence   (confidence)
);

FILE: test/tb_threshold_blob_centroid.sv
// Self-checking testbench for the thresholded blob centroid block.
`timescale 1ns / 100ps

module tb_threshold_blob_centroid;
  import tbc_pkg::*;

  // The run is far shorter than this; hitting it means the block hung.
  localparam int CYCLE_LIMIT = 500000;
  // Long enough for the back end to finish any frame that could still be in
  // flight once the last expected result is out.
  localparam int SETTLE_CYCLES = 150;

  // One frame summary as the result channel presents it.
  typedef struct packed {
    logic              detected;
    logic [CENT_W-1:0] col;
    logic [CENT_W-1:0] row;
    logic [CNT_W-1:0]  area;
    logic [CONF_W-1:0] confidence;
  } frame_summary_t;

  // Pixel content patterns used to build frames.
  typedef enum int {
    FILL_DARK,
    FILL_BRIGHT,
    FILL_BLOB,
    FILL_NOISE,
    FILL_STRIPES,
    FILL_CORNER
  } frame_fill_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic                  detected;
  logic [CENT_W-1:0]     centroid_col;
  logic [CENT_W-1:0]     centroid_row;
  logic [CNT_W-1:0]      area;
  logic [CONF_W-1:0]     confidence;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BRIGHT_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers and the accumulation state of the block.
  logic [PIX_W-1:0]  thr_q;
  logic [CNT_W-1:0]  min_area_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  int                pos_col;
  int                pos_row;
  longint unsigned   sum_col_acc;
  longint unsigned   sum_row_acc;
  longint unsigned   bright_acc;

  // Frame summaries predicted but not yet seen on the result channel.
  frame_summary_t summaries_due[$];

  int mismatches = 0;
  int cycle_count = 0;
  int pixels_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // A long receiver hold-off is asked for by bumping hold_requests.
  int hold_requests = 0;
  int hold_len = 0;
  // Bounds of the bright rectangle for blob frames.
  int blob_c0, blob_c1, blob_r0, blob_r1;

  threshold_blob_centroid u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .detected     (detected),
    .centroid_col (centroid_col),
    .centroid_row (centroid_row),
    .area         (area),
    .confidence   (confidence),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Register values and counters as they stand right after reset.
  function automatic void reset_shadow();
    thr_q = PIX_W'(128);
    min_area_q = CNT_W'(4);
    width_q = SIZE_W'(640);
    height_q = SIZE_W'(480);
    pos_col = 0;
    pos_row = 0;
    sum_col_acc = 0;
    sum_row_acc = 0;
    bright_acc = 0;
  endfunction

  // Frame sizes outside 1..limit are used clamped.
  function automatic int usable_size(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Result for the frame that just ended, from the current sums and count.
  function automatic frame_summary_t summarize_frame();
    frame_summary_t  s;
    longint unsigned ratio;
    s = '0;
    if (bright_acc != 0 && bright_acc >= longint'(min_area_q)) begin
      s.detected = 1'b1;
      s.col = CENT_W'((sum_col_acc << FRAC_BITS) / bright_acc);
      s.row = CENT_W'((sum_row_acc << FRAC_BITS) / bright_acc);
      s.area = CNT_W'(bright_acc);
      if (min_area_q == 0) begin
        ratio = 256;
      end else begin
        ratio = (bright_acc * 256) / (longint'(min_area_q) * 4);
        if (ratio > 256) ratio = 256;
      end
      s.confidence = CONF_W'(ratio);
    end
    return s;
  endfunction

  // Account one accepted pixel; a pixel that closes the frame queues a summary.
  // Counters already past a shrunken size simply wrap at the next pixel.
  function automatic void track_pixel(input logic [PIX_W-1:0] value);
    int w;
    int h;
    w = usable_size(width_q, MAX_WIDTH);
    h = usable_size(height_q, MAX_HEIGHT);
    if (value >= thr_q) begin
      sum_col_acc += longint'(pos_col);
      sum_row_acc += longint'(pos_row);
      bright_acc += 1;
    end
    if (pos_col + 1 < w) begin
      pos_col++;
      return;
    end
    pos_col = 0;
    if (pos_row + 1 < h) begin
      pos_row++;
      return;
    end
    summaries_due.push_back(summarize_frame());
    pos_row = 0;
    sum_col_acc = 0;
    sum_row_acc = 0;
    bright_acc = 0;
  endfunction

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // The receiver drops ready at random, and for a long stretch when a hold
  // is requested; the hold length is counted down here.
  always @(posedge clk) begin : drive_ready
    int holds_served;
    int hold_left;
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every accepted result request is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    frame_summary_t want;
    if (!rst && result_valid && result_ready) begin
      if (summaries_due.size() == 0) begin
        report_mismatch("result request with no frame summary pending");
      end else begin
        want = summaries_due.pop_front();
        if (detected !== want.detected)
          report_mismatch($sformatf("detected %0d, expected %0d", detected, want.detected));
        if (centroid_col !== want.col)
          report_mismatch($sformatf("centroid_col %0d, expected %0d", centroid_col, want.col));
        if (centroid_row !== want.row)
          report_mismatch($sformatf("centroid_row %0d, expected %0d", centroid_row, want.row));
        if (area !== want.area)
          report_mismatch($sformatf("area %0d, expected %0d", area, want.area));
        if (confidence !== want.confidence)
          report_mismatch($sformatf("confidence %0d, expected %0d", confidence,
                                    want.confidence));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one pixel request. When the sender idles, each cycle before the
  // offer is left empty with the idle probability.
  // Valid stays high after acceptance so back-to-back pixels need no gap.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    track_pixel(value);
    pixels_sent++;
  endtask

  task automatic stop_pixels();
    pixel_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pause: wait for every predicted summary, then let the block settle.
  task automatic wait_results_done();
    while (summaries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_BRIGHT_THRESHOLD: thr_q = data[PIX_W-1:0];
      REG_MIN_AREA:         min_area_q = data[CNT_W-1:0];
      REG_FRAME_WIDTH:      width_q = data[SIZE_W-1:0];
      REG_FRAME_HEIGHT:     height_q = data[SIZE_W-1:0];
      default: ;
    endcase
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change once the block has gone idle. The threshold write
  // carries random upper bits, which the 8-bit register must drop.
  task automatic configure(input logic [PIX_W-1:0] thr, input logic [CNT_W-1:0] min_area,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    stop_pixels();
    wait_results_done();
    write_reg(REG_BRIGHT_THRESHOLD, {13'($urandom), thr});
    write_reg(REG_MIN_AREA, CFG_DATA_W'(min_area));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic logic [PIX_W-1:0] bright_value();
    return PIX_W'($urandom_range(255, thr_q));
  endfunction

  // With a zero threshold nothing is dark, so zero is as dark as it gets.
  function automatic logic [PIX_W-1:0] dark_value();
    if (thr_q == 0) return '0;
    return PIX_W'($urandom_range(thr_q - 1, 0));
  endfunction

  // Next pixel of a pattern, chosen from the predicted raster position.
  function automatic logic [PIX_W-1:0] pick_pixel(input frame_fill_t fill);
    int w;
    int h;
    w = usable_size(width_q, MAX_WIDTH);
    h = usable_size(height_q, MAX_HEIGHT);
    case (fill)
      FILL_DARK:    return dark_value();
      FILL_BRIGHT:  return bright_value();
      FILL_BLOB: begin
        if (pos_col >= blob_c0 && pos_col <= blob_c1 && pos_row >= blob_r0 &&
            pos_row <= blob_r1)
          return bright_value();
        return dark_value();
      end
      FILL_STRIPES: return (pos_row % 2 == 0) ? bright_value() : dark_value();
      FILL_CORNER:  return (pos_col == w - 1 && pos_row == h - 1) ? bright_value()
                                                                  : dark_value();
      default:      return PIX_W'($urandom);
    endcase
  endfunction

  // Send pixels of one pattern until the predicted position wraps to the
  // start, i.e. until the frame in progress has ended.
  task automatic finish_frame(input frame_fill_t fill);
    int w;
    int h;
    w = usable_size(width_q, MAX_WIDTH);
    h = usable_size(height_q, MAX_HEIGHT);
    blob_c0 = $urandom_range(w - 1, 0);
    blob_c1 = $urandom_range(w - 1, blob_c0);
    blob_r0 = $urandom_range(h - 1, 0);
    blob_r1 = $urandom_range(h - 1, blob_r0);
    do begin
      send_pixel(pick_pixel(fill));
    end while (pos_col != 0 || pos_row != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Only the frame size is written, so the reset threshold of 128 and the
  // reset minimum area of 4 decide this frame: exactly four bright pixels.
  task automatic test_reset_defaults();
    stop_pixels();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_pixel(8'd0);   send_pixel(8'd127); send_pixel(8'd128); send_pixel(8'd255);
    send_pixel(8'd129); send_pixel(8'd127); send_pixel(8'd200); send_pixel(8'd50);
  endtask

  // A zero threshold makes even black pixels bright, and a zero minimum area
  // gives full confidence; a threshold of 255 lets only white through.
  task automatic test_threshold_extremes();
    configure(8'd0, CNT_W'(0), SIZE_W'(2), SIZE_W'(1));
    send_pixel(8'd0);
    send_pixel(8'd0);
    configure(8'd255, CNT_W'(1), SIZE_W'(2), SIZE_W'(1));
    send_pixel(8'd254);
    send_pixel(8'd255);
  endtask

  // Too few bright pixels, and no bright pixel at all even with a zero
  // minimum area, both give an all-zero summary.
  task automatic test_not_detected();
    configure(8'd255, CNT_W'(3), SIZE_W'(2), SIZE_W'(2));
    send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd0);
    configure(8'd255, CNT_W'(0), SIZE_W'(2), SIZE_W'(2));
    send_pixel(8'd0); send_pixel(8'd10); send_pixel(8'd0); send_pixel(8'd254);
  endtask

  // Confidence clamps at one, and the largest minimum areas reject a frame.
  task automatic test_confidence_limits();
    configure(8'd1, CNT_W'(1), SIZE_W'(3), SIZE_W'(2));
    finish_frame(FILL_BRIGHT);
    configure(8'd0, CNT_W'(21'h1F_FFFF), SIZE_W'(1), SIZE_W'(1));
    send_pixel(8'd9);
    configure(8'd0, CNT_W'(1 << 20), SIZE_W'(1), SIZE_W'(1));
    send_pixel(8'd9);
  endtask

  // Out-of-range sizes clamp: a width of 2047 acts as 1024 and a height of 0
  // as 1, so a lone bright pixel at the far end of the row drives the column
  // centroid to its largest value. A width of 0 then acts as 1.
  task automatic test_extreme_positions();
    configure(8'd255, CNT_W'(1), SIZE_W'(2047), SIZE_W'(0));
    finish_frame(FILL_CORNER);
    configure(8'd255, CNT_W'(1), SIZE_W'(0), SIZE_W'(3));
    finish_frame(FILL_CORNER);
  endtask

  // The counters survive register writes. Shrinking the frame below the
  // current position ends the frame at the next pixel; growing it extends
  // the row in progress.
  task automatic test_resize_mid_frame();
    configure(8'd128, CNT_W'(1), SIZE_W'(4), SIZE_W'(4));
    repeat (11) send_pixel(pick_pixel(FILL_NOISE));
    configure(8'd128, CNT_W'(1), SIZE_W'(2), SIZE_W'(2));
    finish_frame(FILL_NOISE);
    send_pixel(pick_pixel(FILL_NOISE));
    configure(8'd128, CNT_W'(1), SIZE_W'(5), SIZE_W'(3));
    finish_frame(FILL_BLOB);
  endtask

  // One-pixel frames make every pixel request end a frame. With the receiver
  // held off, the summary queue fills and the block must stall its input.
  // Afterwards the sender pauses until every summary has come out.
  task automatic test_backpressure();
    configure(8'd100, CNT_W'(1), SIZE_W'(1), SIZE_W'(1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 400;
    hold_requests++;
    repeat (30) send_pixel(PIX_W'($urandom));
    stop_pixels();
    wait_results_done();
    recv_idle_pct = 32;
    repeat (20) send_pixel(PIX_W'($urandom));
  endtask

  // Mostly complete frames with random content under random settings, with
  // the odd broken frame left half done before the next size change.
  task automatic test_random_frames(input int send_pct, input int recv_pct, input int budget);
    int                start_count;
    int                w;
    int                h;
    int                frame_px;
    int                frames;
    int                partial;
    logic [CNT_W-1:0]  min_area_pick;
    logic [SIZE_W-1:0] width_raw;
    start_count = pixels_sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (pixels_sent - start_count < budget) begin
      w = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      frame_px = w * h;
      case ($urandom_range(5, 0))
        0:       min_area_pick = '0;
        1:       min_area_pick = CNT_W'(1);
        2, 3:    min_area_pick = CNT_W'($urandom_range(frame_px, 1));
        4:       min_area_pick = CNT_W'($urandom_range(frame_px / 4 + 1, 1));
        default: min_area_pick = CNT_W'($urandom);
      endcase
      // A width of zero behaves as one.
      width_raw = (w == 1 && $urandom_range(1, 0) == 0) ? '0 : SIZE_W'(w);
      configure(PIX_W'($urandom), min_area_pick, width_raw, SIZE_W'(h));
      frames = $urandom_range(4, 2);
      repeat (frames) finish_frame(frame_fill_t'($urandom_range(FILL_CORNER, FILL_DARK)));
      if ($urandom_range(5, 0) == 0) begin
        partial = $urandom_range(frame_px - 1, 0);
        repeat (partial) send_pixel(pick_pixel(FILL_NOISE));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_extremes();
    test_not_detected();
    test_confidence_limits();
    test_extreme_positions();
    test_resize_mid_frame();
    test_backpressure();
    test_random_frames(32, 60, 40);
    test_random_frames(60, 32, 40);
    test_random_frames(0, 0, 40);

    stop_pixels();
    wait_results_done();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/tbc_pkg.sv
src/tbc_front.sv
src/tbc_queue.sv
src/tbc_div.sv
src/tbc_back.sv
src/threshold_blob_centroid.sv
src/tbc_checker.sv
test/tb_threshold_blob_centroid.sv
